// ===== rtl/lstr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and log table generator for the log scope trace renderer.
package lstr_pkg;

    localparam int COLUMNS_DEF    = 128;
    localparam int LOG_ENTRIES_DEF = 1024;

    localparam int SAMPLE_W = 16;
    localparam int COL_W    = 7;
    localparam int FRAC_W   = 15;
    localparam int LOG_W    = 17;
    localparam int HALF_W   = 7;
    localparam int PROD_W   = 24;
    localparam int ROW_W    = 8;
    localparam int PX_W     = 10;
    localparam int PY_W     = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_HEIGHT = 2'd3;

    localparam logic [63:0] LOG10_2_Q32 = 64'd1292913987;

    // Sideband that rides along the pipeline with each sample.
    typedef struct packed {
        logic             v;
        logic             neg;
        logic [COL_W-1:0] col;
    } t_tag;

    // log2(n) in Q.32 by repeated squaring; elaboration only.
    function automatic logic [63:0] lstr_log2_q32(input logic [31:0] n);
        logic [5:0]  p;
        logic [63:0] y;
        logic [31:0] frac;
        p    = 6'd0;
        frac = 32'd0;
        for (int i = 1; i < 32; i++) begin
            if ((n >> i) != 32'd0) begin
                p = 6'(i);
            end
        end
        y = 64'(n) << (6'd30 - p);
        for (int b = 31; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= 64'h0000_0000_8000_0000) begin
                y       = y >> 1;
                frac[b] = 1'b1;
            end
        end
        return {26'd0, p, frac};
    endfunction

    // Entry k of the Q1.16 table of log10(1 + 9k/e), clamped to 1.0.
    function automatic logic [LOG_W-1:0] lstr_log_entry(input int unsigned e,
                                                        input int unsigned k);
        logic [63:0] base;
        logic [63:0] d;
        logic [63:0] v;
        base = lstr_log2_q32(32'(e));
        d    = lstr_log2_q32(32'(e + 9 * k)) - base;
        v    = ((d >> 8) * LOG10_2_Q32 + (64'd1 << 39)) >> 40;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return LOG_W'(v);
    endfunction

endpackage

// ===== rtl/lstr_log_rom.sv =====
`timescale 1ns / 1ps
// Log table ROM with two registered read ports.
module lstr_log_rom #(
    parameter int LOG_TABLE_ENTRIES = lstr_pkg::LOG_ENTRIES_DEF,
    parameter int AW = $clog2(LOG_TABLE_ENTRIES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [AW-1:0]              i_addr_a,
    input  logic [AW-1:0]              i_addr_b,
    output logic [lstr_pkg::LOG_W-1:0] o_data_a,
    output logic [lstr_pkg::LOG_W-1:0] o_data_b
);
    import lstr_pkg::*;

    logic [LOG_W-1:0] w_rom [0:LOG_TABLE_ENTRIES];
    logic [LOG_W-1:0] r_data_a;
    logic [LOG_W-1:0] r_data_b;

    for (genvar k = 0; k <= LOG_TABLE_ENTRIES; k++) begin : g_rom
        localparam logic [LOG_W-1:0] VAL = lstr_log_entry(LOG_TABLE_ENTRIES, k);
        assign w_rom[k] = VAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= w_rom[i_addr_a];
            r_data_b <= w_rom[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// ===== rtl/lstr_map_pipe.sv =====
`timescale 1ns / 1ps
// Magnitude to scaled log value pipeline: table lookup, interpolation, scaling.
module lstr_map_pipe #(
    parameter int LOG_TABLE_ENTRIES = lstr_pkg::LOG_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_vld,
    input  logic [lstr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [lstr_pkg::COL_W-1:0]    i_col,
    input  logic [lstr_pkg::HALF_W-1:0]   i_half,
    output lstr_pkg::t_tag                o_tag,
    output logic [lstr_pkg::PROD_W-1:0]   o_prod
);
    import lstr_pkg::*;

    localparam int AW = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int PW = FRAC_W + AW;
    localparam logic [AW-1:0] IDX_LAST = AW'(LOG_TABLE_ENTRIES);

    t_tag                r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;
    logic [SAMPLE_W-1:0] r_s1_mag;
    logic [FRAC_W-1:0]   r_s2_f;
    logic [31:0]         r_s3_prod;
    logic [LOG_W-1:0]    r_s3_a;
    logic [LOG_W-1:0]    r_s4_l;
    logic [PROD_W-1:0]   r_s5_prod;

    logic [PW-1:0]       w_pos;
    logic [AW-1:0]       w_idx;
    logic [AW-1:0]       w_idx_b;
    logic [LOG_W-1:0]    w_a;
    logic [LOG_W-1:0]    w_b;
    logic [SAMPLE_W-1:0] w_mag;

    // -32768 wraps to 0x8000, which is the right magnitude
    assign w_mag = i_sample[SAMPLE_W-1] ? (~i_sample + 16'd1) : i_sample;

    assign w_pos   = PW'(r_s1_mag) * PW'(LOG_TABLE_ENTRIES);
    assign w_idx   = w_pos[PW-1:FRAC_W];
    // full-scale magnitude lands on the last entry with zero fraction
    assign w_idx_b = (w_idx == IDX_LAST) ? w_idx : w_idx + AW'(1);

    lstr_log_rom #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
        .AW                (AW)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (i_adv),
        .i_addr_a (w_idx),
        .i_addr_b (w_idx_b),
        .o_data_a (w_a),
        .o_data_b (w_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_tag <= '0;
            r_s4_tag <= '0;
            r_s5_tag <= '0;
        end else if (i_adv) begin
            r_s1_tag <= '{v: i_vld, neg: i_sample[SAMPLE_W-1], col: i_col};
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= r_s3_tag;
            r_s5_tag <= r_s4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_mag  <= w_mag;
            r_s2_f    <= w_pos[FRAC_W-1:0];
            r_s3_prod <= 32'(w_b - w_a) * 32'(r_s2_f);
            r_s3_a    <= w_a;
            r_s4_l    <= r_s3_a + LOG_W'(r_s3_prod >> FRAC_W);
            r_s5_prod <= PROD_W'(i_half) * PROD_W'(r_s4_l);
        end
    end

    assign o_tag  = r_s5_tag;
    assign o_prod = r_s5_prod;

endmodule

// ===== rtl/lstr_row_out.sv =====
`timescale 1ns / 1ps
// Row compute, per-column row store and erase/draw command output.
module lstr_row_out #(
    parameter int COLUMNS = lstr_pkg::COLUMNS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lstr_pkg::t_tag              i_tag,
    input  logic [lstr_pkg::PROD_W-1:0] i_prod,
    input  logic [lstr_pkg::HALF_W-1:0] i_half,
    input  logic [lstr_pkg::CFG_W-1:0]  i_origin_x,
    input  logic [lstr_pkg::ROW_W-1:0]  i_origin_y,
    output logic                        o_adv,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // pixel_x[9:0], pixel_y[18:10]
    output logic                        m_axis_tuser,  // pixel_kind
    output logic                        m_axis_tlast   // last
);
    import lstr_pkg::*;

    localparam int CW = $clog2(COLUMNS);

    t_tag              r_s6_tag;
    logic [PROD_W-1:0] r_s6_prod;
    logic [ROW_W-1:0]  r_s6_old;
    logic [COLUMNS-1:0] r_vld;
    logic [ROW_W-1:0]  r_old_rows [COLUMNS];

    logic              r_out_vld;
    logic              r_out_draw;
    logic [PX_W-1:0]   r_out_x;
    logic [PY_W-1:0]   r_out_y;
    logic [PY_W-1:0]   r_draw_y;

    logic [PY_W-1:0]   w_up;
    logic [PY_W-1:0]   w_dn;
    logic [ROW_W-1:0]  w_row;
    logic              w_emit;
    logic              w_can_load;
    logic              w_fwd;
    logic [CW-1:0]     w_rd_idx;
    logic [CW-1:0]     w_wr_idx;

    // negative side rounds the offset up so the row is the floor of half - half*L
    assign w_up  = PY_W'((25'(r_s6_prod) + 25'h00FFFF) >> 16);
    assign w_dn  = PY_W'(r_s6_prod >> 16);
    assign w_row = r_s6_tag.neg ? ROW_W'(PY_W'(i_half) - w_up)
                                : ROW_W'(PY_W'(i_half) + w_dn);

    assign w_emit     = r_s6_tag.v && (w_row != r_s6_old);
    assign w_can_load = !r_out_vld || (m_axis_tready && r_out_draw);
    assign o_adv      = !w_emit || w_can_load;

    assign w_rd_idx = CW'(i_tag.col);
    assign w_wr_idx = CW'(r_s6_tag.col);
    // the beat leaving now updates the column the next beat is about to read
    assign w_fwd    = w_emit && (r_s6_tag.col == i_tag.col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_tag <= '0;
            r_vld    <= '0;
        end else if (o_adv) begin
            r_s6_tag <= i_tag;
            if (w_emit) begin
                r_vld[w_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s6_prod <= i_prod;
            r_s6_old  <= w_fwd ? w_row : (r_vld[w_rd_idx] ? r_old_rows[w_rd_idx] : '0);
            if (w_emit) begin
                r_old_rows[w_wr_idx] <= w_row;
            end
        end
    end

    // erase beat first, draw beat held behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_draw <= 1'b0;
        end else if (o_adv && w_emit) begin
            r_out_vld  <= 1'b1;
            r_out_draw <= 1'b0;
        end else if (r_out_vld && m_axis_tready) begin
            if (r_out_draw) begin
                r_out_vld <= 1'b0;
            end else begin
                r_out_draw <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && w_emit) begin
            r_out_x  <= PX_W'(i_origin_x) + PX_W'(r_s6_tag.col);
            r_out_y  <= PY_W'(i_origin_y) + PY_W'(r_s6_old);
            r_draw_y <= PY_W'(i_origin_y) + PY_W'(w_row);
        end else if (r_out_vld && m_axis_tready && !r_out_draw) begin
            r_out_y <= r_draw_y;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_draw;
    assign m_axis_tlast  = r_out_draw;

endmodule

// ===== rtl/log_scope_trace_renderer.sv =====
`timescale 1ns / 1ps
// A sample that moves its row shows its erase beat after the map pipeline, row stage and
// output registers; the draw beat follows on the next cycle the output is taken.
// Throughput: one sample per cycle when the row does not move or the column is out of
// range; a moving sample sends erase and draw beats on the single pixel output port.
// Reset: synchronous, active low; clears pipeline valids and stored-row valids, sets config defaults.
module log_scope_trace_renderer #(
    parameter int COLUMNS           = lstr_pkg::COLUMNS_DEF,
    parameter int LOG_TABLE_ENTRIES = lstr_pkg::LOG_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lstr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lstr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // sample[15:0], column[22:16]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // pixel_x[9:0], pixel_y[18:10]
    output logic                           m_axis_tuser,  // pixel_kind
    output logic                           m_axis_tlast   // last
);
    import lstr_pkg::*;

    logic [CFG_W-1:0]  r_origin_x;
    logic [ROW_W-1:0]  r_origin_y;
    logic [ROW_W-1:0]  r_trace_width;
    logic [HALF_W-1:0] r_half;

    logic                w_adv;
    logic                w_in_range;
    logic [COL_W-1:0]    w_col;
    t_tag                w_tag;
    logic [PROD_W-1:0]   w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_trace_width <= 8'd128;
            r_half        <= 7'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X:     r_origin_x    <= i_cfg_data;
                CFG_ORIGIN_Y:     r_origin_y    <= i_cfg_data[7:0];
                CFG_TRACE_WIDTH:  r_trace_width <= i_cfg_data[7:0];
                CFG_TRACE_HEIGHT: r_half        <= i_cfg_data[7:1];
                default:          r_half        <= r_half;
            endcase
        end
    end

    assign w_col      = s_axis_tdata[22:16];
    // drop columns past the trace or the row store
    assign w_in_range = (ROW_W'(w_col) < r_trace_width) && (9'(w_col) < 9'(COLUMNS));
    assign s_axis_tready = w_adv;

    lstr_map_pipe #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (s_axis_tvalid && w_in_range),
        .i_sample (s_axis_tdata[15:0]),
        .i_col    (w_col),
        .i_half   (r_half),
        .o_tag    (w_tag),
        .o_prod   (w_prod)
    );

    lstr_row_out #(
        .COLUMNS (COLUMNS)
    ) u_row (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (w_tag),
        .i_prod        (w_prod),
        .i_half        (r_half),
        .i_origin_x    (r_origin_x),
        .i_origin_y    (r_origin_y),
        .o_adv         (w_adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_stall_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output pending");

    a_draw_after_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tuser) |=> (m_axis_tvalid && m_axis_tuser))
        else $error("erase beat not followed by draw beat");

    a_same_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tuser)
        |=> (m_axis_tdata[9:0] == $past(m_axis_tdata[9:0])))
        else $error("draw beat column differs from erase beat");

    a_last_on_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> $past(w_adv) || $stable(m_axis_tdata[9:0]))
        else $error("draw beat lost its column");

endmodule
